>>> sv/tkdc_pkg.sv
// Package for the three-key debouncer: widths, register indexes, LED and
// action codes, and the packed result layout.
// No dependencies.
package tkdc_pkg;

    localparam int NUM_KEYS     = 3;
    localparam int DB_W         = 8;
    localparam int HOLD_W       = 10;
    localparam int LED_W        = 3;
    localparam int ACT_W        = 2;
    localparam int KEY_IDX_W    = 2;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [DB_W-1:0]   DB_MAX            = '1;
    localparam logic [DB_W-1:0]   RST_RELEASE_TICKS = 8'd10;
    localparam logic [HOLD_W-1:0] RST_HOLD_THRESH   = 10'd500;
    localparam logic [HOLD_W-1:0] RST_HOLD_CAP      = 10'd600;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RELEASE_TICKS  = 2'd0,
        REG_HOLD_THRESHOLD = 2'd1,
        REG_HOLD_CAP       = 2'd2,
        REG_LED_MODE       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        LED_MODE_NORMAL    = 2'd0,
        LED_MODE_OFTEN_ON  = 2'd1,
        LED_MODE_OFTEN_OFF = 2'd2
    } t_led_mode;

    typedef enum logic [LED_W-1:0] {
        LED_NONE        = 3'd0,
        LED_DIRECT_ZERO = 3'd1,
        LED_DIRECT_FULL = 3'd2,
        LED_FADE_FULL   = 3'd3,
        LED_FADE_ZERO   = 3'd4
    } t_led_cmd;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE        = 2'd0,
        ACT_KEY3_MODE   = 2'd1,
        ACT_KEY12_MODE  = 2'd2,
        ACT_BACKGROUND  = 2'd3
    } t_action;

    // Declared from the top field down, so key_changed lands in bit 0.
    typedef struct packed {
        logic [KEY_IDX_W-1:0] last_key;
        logic [NUM_KEYS-1:0]  held_mask;
        logic [ACT_W-1:0]     setting_action;
        logic [LED_W-1:0]     led1_cmd;
        logic [LED_W-1:0]     led0_cmd;
        logic [NUM_KEYS-1:0]  released_mask;
        logic [NUM_KEYS-1:0]  pressed_mask;
        logic                 key_changed;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // Action fired by a long press of each key.
    function automatic t_action key_action(input logic [KEY_IDX_W-1:0] key);
        t_action act;
        case (key)
            2'd0:    act = ACT_KEY12_MODE;
            2'd1:    act = ACT_BACKGROUND;
            2'd2:    act = ACT_KEY3_MODE;
            default: act = ACT_NONE;
        endcase
        return act;
    endfunction

endpackage

>>> sv/three_key_debounce_combo.sv
// Three-key debouncer with long-press combos: top level.
// Depends on tkdc_pkg.
//
// Usage:
//   Slave stream: one beat per 1 ms tick; tdata[2:0] are the raw active-low
//   levels of keys 0..2. Master stream: one result beat per tick.
//   Configuration channel: i_cfg_valid/o_cfg_ready with a register index
//   (0 release_ticks, 1 hold_threshold, 2 hold_cap, 3 led_mode) and data.
//   o_cfg_ready is always high; write only while no tick is in flight.
// Timing:
//   The whole key update is one combinational pass from the key state
//   registers into the result register, so while o_s_axis_tready is high a
//   tick is accepted every cycle; its result is registered in the result
//   register, or in the skid register if the receiver stalls.
// Reset and stalls:
//   Reset sets all keys idle, hold counters and last key to zero, and the
//   registers to 10, 500, 600 and 0. A result register plus one skid
//   register sit on the output; if the receiver stalls, one more tick is
//   taken into the skid register, and then o_s_axis_tready drops until the
//   receiver takes a beat.
module three_key_debounce_combo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [2:0] key_levels, [7:3] zero
    input  logic [tkdc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] key_changed, [3:1] pressed_mask, [6:4] released_mask,
    // [9:7] led0_cmd, [12:10] led1_cmd, [14:13] setting_action,
    // [17:15] held_mask, [19:18] last_key, [23:20] zero
    output logic [tkdc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tkdc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tkdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tkdc_pkg::*;

    // Configuration
    logic [DB_W-1:0]     r_release_ticks;
    logic [HOLD_W-1:0]   r_hold_thresh;
    logic [HOLD_W-1:0]   r_hold_cap;
    logic [1:0]          r_led_mode;

    // Key state
    logic [DB_W-1:0]      r_db   [NUM_KEYS];
    logic [HOLD_W-1:0]    r_hold [NUM_KEYS];
    logic [KEY_IDX_W-1:0] r_last;

    logic [DB_W-1:0]      n_db   [NUM_KEYS];
    logic [HOLD_W-1:0]    n_hold [NUM_KEYS];
    logic [KEY_IDX_W-1:0] n_last;

    // Output result register and skid register
    t_result r_out;
    logic    r_out_vld;
    t_result r_skid;
    logic    r_skid_vld;
    t_result n_res;

    logic s_accept;
    logic m_take;
    logic cfg_we;

    assign o_cfg_ready     = 1'b1;
    assign cfg_we          = i_cfg_valid & o_cfg_ready;
    assign o_s_axis_tready = ~r_skid_vld;
    assign s_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign m_take          = r_out_vld & i_m_axis_tready;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), r_out};

    // Key update: keys run in order, and each later key sees the counts and
    // last key that earlier keys wrote in the same tick.
    always_comb begin
        logic [NUM_KEYS-1:0] levels;
        logic [NUM_KEYS-1:0] pmask;
        logic [NUM_KEYS-1:0] rmask;
        logic [NUM_KEYS-1:0] hmask;
        logic                all_down;
        t_action             act;
        t_led_cmd            led_press;
        t_led_cmd            led_release;

        levels   = i_s_axis_tdata[NUM_KEYS-1:0];
        pmask    = '0;
        rmask    = '0;
        hmask    = '0;
        act      = ACT_NONE;
        n_db     = r_db;
        n_hold   = r_hold;
        n_last   = r_last;
        all_down = 1'b0;

        for (int k = 0; k < NUM_KEYS; k++) begin
            if (n_db[k] == '0) begin
                if (!levels[k]) begin
                    n_db[k]  = DB_W'(1);
                    pmask[k] = 1'b1;
                    n_last   = KEY_IDX_W'(k);
                end
            end else if (levels[k] &&
                         ((n_db[k] == DB_MAX ? n_db[k] : n_db[k] + DB_W'(1))
                          >= r_release_ticks)) begin
                n_db[k]   = '0;
                n_hold[k] = '0;
                rmask[k]  = 1'b1;
            end else begin
                if (levels[k]) begin
                    if (n_db[k] != DB_MAX) n_db[k] = n_db[k] + DB_W'(1);
                end else begin
                    n_db[k] = DB_W'(1);
                end
                if (n_hold[k] < r_hold_cap) n_hold[k] = n_hold[k] + HOLD_W'(1);
                if (n_hold[k] > r_hold_thresh) begin
                    n_hold[k] = '0;
                    // This key is itself down here; the combo also needs the other two.
                    all_down = (n_db[0] != '0) && (n_db[1] != '0) && (n_db[2] != '0);
                    if (all_down && n_last == KEY_IDX_W'(k))
                        act = key_action(KEY_IDX_W'(k));
                end
            end
        end

        for (int k = 0; k < NUM_KEYS; k++) begin
            hmask[k] = (n_db[k] != '0);
        end

        case (r_led_mode)
            LED_MODE_OFTEN_ON: begin
                led_press   = LED_DIRECT_ZERO;
                led_release = LED_FADE_FULL;
            end
            LED_MODE_OFTEN_OFF: begin
                led_press   = LED_DIRECT_FULL;
                led_release = LED_FADE_ZERO;
            end
            default: begin
                led_press   = LED_NONE;
                led_release = LED_NONE;
            end
        endcase

        n_res.key_changed    = |(pmask | rmask);
        n_res.pressed_mask   = pmask;
        n_res.released_mask  = rmask;
        n_res.led0_cmd       = pmask[0] ? led_press : (rmask[0] ? led_release : LED_NONE);
        n_res.led1_cmd       = pmask[1] ? led_press : (rmask[1] ? led_release : LED_NONE);
        n_res.setting_action = act;
        n_res.held_mask      = hmask;
        n_res.last_key       = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_ticks <= RST_RELEASE_TICKS;
            r_hold_thresh   <= RST_HOLD_THRESH;
            r_hold_cap      <= RST_HOLD_CAP;
            r_led_mode      <= LED_MODE_NORMAL;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_db[k]   <= '0;
                r_hold[k] <= '0;
            end
            r_last     <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (i_cfg_addr)
                    REG_RELEASE_TICKS:  r_release_ticks <= i_cfg_data[DB_W-1:0];
                    REG_HOLD_THRESHOLD: r_hold_thresh   <= i_cfg_data[HOLD_W-1:0];
                    REG_HOLD_CAP:       r_hold_cap      <= i_cfg_data[HOLD_W-1:0];
                    REG_LED_MODE:       r_led_mode      <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (s_accept) begin
                r_db   <= n_db;
                r_hold <= n_hold;
                r_last <= n_last;
            end

            if (r_skid_vld) begin
                if (m_take) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end
            end else if (s_accept) begin
                if (!r_out_vld || m_take) begin
                    r_out     <= n_res;
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid     <= n_res;
                    r_skid_vld <= 1'b1;
                end
            end else if (m_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // The skid register only fills behind a waiting result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while result register empty");

    // A tick taken while the result is stalled must land in the skid register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_out_vld && !i_m_axis_tready) |=> r_skid_vld)
        else $error("tick accepted under stall was not kept");

    // A key cannot be pressed and released in the same tick.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out.pressed_mask & r_out.released_mask) == '0))
        else $error("key both pressed and released in one tick");

    // A pressed key is held after the tick; a released key is not.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (((r_out.pressed_mask & ~r_out.held_mask) == '0) &&
                       ((r_out.released_mask & r_out.held_mask) == '0)))
        else $error("held mask disagrees with press or release");

    // The change flag follows the two masks.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.key_changed ==
                       ((r_out.pressed_mask | r_out.released_mask) != '0)))
        else $error("key_changed disagrees with masks");

endmodule
